>>> hdl/gbb_pkg.sv
package gbb_pkg;

  localparam int unsigned DEF_MAX_WIDTH      = 2048;
  localparam int unsigned DEF_MAX_HEIGHT     = 2048;
  localparam int unsigned RESET_IMAGE_WIDTH  = 640;
  localparam int unsigned RESET_IMAGE_HEIGHT = 480;

  localparam int unsigned CFG_W = 12;
  localparam int unsigned IDX_W = 1;

  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned RGB_SUM_W  = 10;
  localparam int unsigned RGB_PROD_W = 20;
  localparam int unsigned COL_SUM_W  = 10;
  localparam int unsigned WIN_SUM_W  = 12;
  localparam int unsigned DIV9_PROD_W = 25;

  // floor(x/3) for x <= 765 and floor(x/9) for x <= 2299 by reciprocal multiply
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam int unsigned DIV9_MUL   = 7282;
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned ROUND_BIAS = 4;

  // previous window columns kept in the cell chain
  localparam int unsigned WIN_CELLS = 2;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [GRAY_W-1:0] gray_t;

  typedef struct packed {
    logic  req_type;
    gray_t red;
    gray_t green;
    gray_t blue;
  } pix_t;

  typedef struct packed {
    gray_t blurred_pixel;
    logic  frame_end;
  } blur_t;

  // one window column: two rows above and the current row
  typedef struct packed {
    gray_t top;
    gray_t mid;
    gray_t bot;
  } col_t;

  typedef struct packed {
    gray_t above;
    gray_t two_above;
  } lb_entry_t;

  function automatic logic [COL_SUM_W-1:0] col_sum(input col_t col);
    col_sum = COL_SUM_W'(col.top) + COL_SUM_W'(col.mid) + COL_SUM_W'(col.bot);
  endfunction

endpackage

>>> hdl/gbb_line_buf.sv
module gbb_line_buf import gbb_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output lb_entry_t                rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  lb_entry_t                wr_data
);

  lb_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/gbb_col_cell.sv
module gbb_col_cell import gbb_pkg::*; (
  input  logic                 clk,
  input  logic                 shift,
  input  col_t                 col_in,
  output col_t                 col_out,
  output logic [COL_SUM_W-1:0] total
);

  // column and its sum move one place per beat
  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
      total   <= col_sum(col_in);
    end
  end

endmodule

>>> hdl/gray_box_blur_3x3.sv
// A result passes s1, s2 and the output queue after the beat completing its window.
// Throughput: one item per cycle while pix_ready is high; the line buffer does one read
// and one write per cycle, with a bypass when consecutive items hit the same column.
// Results are owed one row plus one pixel behind the input; drain beats flush them.
// Reset: position, result count and pipeline cleared, width 640, height 480.
// The line buffer is not cleared; rows above the image are masked to zero.
module gray_box_blur_3x3 import gbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  pix_t             pix,
  output logic             blur_valid,
  input  logic             blur_ready,
  output blur_t            blur,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned RLW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned CWW = (CFG_W > WW) ? CFG_W : WW;
  localparam int unsigned CWH = (CFG_W > HW) ? CFG_W : HW;
  localparam int unsigned RST_W = (RESET_IMAGE_WIDTH > MAX_WIDTH) ?
                                  MAX_WIDTH : RESET_IMAGE_WIDTH;
  localparam int unsigned RST_H = (RESET_IMAGE_HEIGHT > MAX_HEIGHT) ?
                                  MAX_HEIGHT : RESET_IMAGE_HEIGHT;
  localparam int unsigned FAW = $clog2(FIFO_DEPTH);
  localparam int unsigned FCW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [AW-1:0] addr;
    gray_t         gray;
    logic          r1;     // row >= 1
    logic          r2;     // row >= 2
    logic          c0;     // first column
    logic          c1;     // second column
    logic          w2;     // width >= 2
    logic          emit;
    logic          last;
    logic          fwd;    // entry written by the previous beat
  } s1_t;

  // config and position
  logic [WW-1:0]  img_w, img_w_next;
  logic [HW-1:0]  img_h, img_h_next;
  logic [AW-1:0]  col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [RLW-1:0] results_left, results_left_next;

  logic [CWW-1:0]      cfg_ext_w;
  logic [CWH-1:0]      cfg_ext_h;
  logic [WW-1:0]       sat_w;
  logic [HW-1:0]       sat_h;

  logic                accept;
  logic                is_drain;
  logic                past_end;
  logic                take;
  logic                first;
  logic [WW+HW-1:0]    area;
  logic [RLW-1:0]      rl_cur;
  logic                emit;
  logic                last;
  logic [WW-1:0]       col_inc;
  logic                wrap;
  logic [RGB_SUM_W-1:0]  rgb_sum;
  logic [RGB_PROD_W-1:0] rgb_prod;
  gray_t               gray;

  logic                s1_valid;
  s1_t                 s1;

  lb_entry_t           lb_rd;
  lb_entry_t           lb_wr;
  lb_entry_t           fwd_q;
  lb_entry_t           entry;
  col_t                new_col;
  logic [COL_SUM_W-1:0] new_sum;
  col_t                cell_col [WIN_CELLS];
  logic [COL_SUM_W-1:0] cell_sum [WIN_CELLS];
  logic [WIN_SUM_W-1:0] win_sum;

  logic                 s2_valid;
  logic [WIN_SUM_W-1:0] s2_sum;
  logic                 s2_last;

  logic [WIN_SUM_W-1:0]   rounded;
  logic [DIV9_PROD_W-1:0] q_prod;

  blur_t               fifo_mem [FIFO_DEPTH];
  logic [FAW-1:0]      wr_ptr;
  logic [FAW-1:0]      rd_ptr;
  logic [FCW-1:0]      fifo_count;
  logic [FCW:0]        credit;
  logic                fifo_pop;

  // ---------------- input stage ----------------

  assign cfg_ext_w = CWW'(cfg_data);
  assign cfg_ext_h = CWH'(cfg_data);
  assign sat_w = (cfg_data == '0) ? WW'(1) :
                 (cfg_ext_w > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_ext_w);
  assign sat_h = (cfg_data == '0) ? HW'(1) :
                 (cfg_ext_h > CWH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_ext_h);

  assign credit    = (FCW+1)'(fifo_count) + (FCW+1)'(s1_valid) + (FCW+1)'(s2_valid);
  assign pix_ready = !rst && (credit < (FCW+1)'(FIFO_DEPTH));

  assign accept   = pix_valid && pix_ready;
  assign is_drain = pix.req_type == REQ_DRAIN;
  assign past_end = row >= RW'(img_h);
  // pixels only before frame end, drain beats only after it
  assign take     = accept && (is_drain == past_end);
  assign first    = (row == '0) && (col == '0);
  assign area     = (WW+HW)'(img_w) * (WW+HW)'(img_h);
  assign rl_cur   = first ? RLW'(area) : results_left;
  assign emit     = ((row >= RW'(2)) || ((row == RW'(1)) && (col != '0))) &&
                    (rl_cur != '0);
  assign last     = emit && (rl_cur == RLW'(1));
  assign col_inc  = WW'(col) + WW'(1);
  assign wrap     = col_inc >= img_w;

  assign rgb_sum  = RGB_SUM_W'(pix.red) + RGB_SUM_W'(pix.green) + RGB_SUM_W'(pix.blue);
  assign rgb_prod = RGB_PROD_W'(rgb_sum) * RGB_PROD_W'(DIV3_MUL);
  assign gray     = rgb_prod[DIV3_SHIFT +: GRAY_W];

  always_comb begin
    img_w_next        = img_w;
    img_h_next        = img_h;
    col_next          = col;
    row_next          = row;
    results_left_next = results_left;
    if (cfg_we) begin
      col_next          = '0;
      row_next          = '0;
      results_left_next = '0;
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:  img_w_next = sat_w;
        REG_IMAGE_HEIGHT: img_h_next = sat_h;
        default: ;
      endcase
    end else if (take) begin
      if (last) begin
        col_next          = '0;
        row_next          = '0;
        results_left_next = '0;
      end else begin
        col_next          = wrap ? '0 : AW'(col_inc);
        row_next          = wrap ? RW'(row + RW'(1)) : row;
        results_left_next = emit ? RLW'(rl_cur - RLW'(1)) : rl_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w        <= WW'(RST_W);
      img_h        <= HW'(RST_H);
      col          <= '0;
      row          <= '0;
      results_left <= '0;
    end else begin
      img_w        <= img_w_next;
      img_h        <= img_h_next;
      col          <= col_next;
      row          <= row_next;
      results_left <= results_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.addr <= col;
      s1.gray <= is_drain ? '0 : gray;
      s1.r1   <= row >= RW'(1);
      s1.r2   <= row >= RW'(2);
      s1.c0   <= col == '0;
      s1.c1   <= col == AW'(1);
      s1.w2   <= img_w >= WW'(2);
      s1.emit <= emit;
      s1.last <= last;
      s1.fwd  <= s1_valid && (s1.addr == col);
    end
  end

  // ---------------- window stage ----------------

  gbb_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col),
    .rd_data (lb_rd),
    .wr_en   (s1_valid),
    .wr_addr (s1.addr),
    .wr_data (lb_wr)
  );

  assign entry = s1.fwd ? fwd_q : lb_rd;

  always_comb begin
    new_col.top = s1.r2 ? entry.two_above : '0;
    new_col.mid = s1.r1 ? entry.above : '0;
    new_col.bot = s1.gray;
  end

  assign lb_wr.above     = s1.gray;
  assign lb_wr.two_above = entry.above;
  assign new_sum         = col_sum(new_col);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_q <= lb_wr;
    end
  end

  for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
    gbb_col_cell u_cell (
      .clk     (clk),
      .shift   (s1_valid),
      .col_in  ((i == 0) ? new_col : cell_col[(i == 0) ? 0 : i - 1]),
      .col_out (cell_col[i]),
      .total   (cell_sum[i])
    );
  end

  // cell 0 holds the newest column, cell 1 the one before
  always_comb begin
    if (s1.c0) begin
      // center sits at the end of the previous row, right side is padding
      win_sum = WIN_SUM_W'(cell_sum[0]) + (s1.w2 ? WIN_SUM_W'(cell_sum[1]) : '0);
    end else if (s1.c1) begin
      win_sum = WIN_SUM_W'(cell_sum[0]) + WIN_SUM_W'(new_sum);
    end else begin
      win_sum = WIN_SUM_W'(cell_sum[1]) + WIN_SUM_W'(cell_sum[0]) +
                WIN_SUM_W'(new_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_sum  <= win_sum;
      s2_last <= s1.last;
    end
  end

  // ---------------- divide and output queue ----------------

  assign rounded = s2_sum + WIN_SUM_W'(ROUND_BIAS);
  assign q_prod  = DIV9_PROD_W'(rounded) * DIV9_PROD_W'(DIV9_MUL);

  assign fifo_pop   = blur_valid && blur_ready;
  assign blur_valid = fifo_count != '0;
  assign blur       = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_mem[wr_ptr].blurred_pixel <= q_prod[DIV9_SHIFT +: GRAY_W];
      fifo_mem[wr_ptr].frame_end     <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= FAW'(wr_ptr + FAW'(1));
      end
      if (fifo_pop) begin
        rd_ptr <= FAW'(rd_ptr + FAW'(1));
      end
      fifo_count <= FCW'(fifo_count + FCW'(s2_valid) - FCW'(fifo_pop));
    end
  end

  // ---------------- checks ----------------

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= (FCW+1)'(FIFO_DEPTH))
    else $error("output queue overcommitted");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.fwd |-> $past(s1_valid))
    else $error("bypass taken without a preceding write");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    take && last |=> (col == '0) && (row == '0) && (results_left == '0))
    else $error("frame did not restart after its last result");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WW'(col) < img_w)
    else $error("column position beyond image width");

endmodule
